[design/cbph_pkg.sv]
// Package for the chained block prefix hash: widths, constants, item types
// and the mix function. No dependencies.
package cbph_pkg;

  localparam int unsigned MAX_BLOCK_SIZE = 4096;
  localparam int unsigned HASH_W         = 64;
  localparam int unsigned BLOCK_SIZE_W   = 13;
  localparam int unsigned COUNT_W        = $clog2(MAX_BLOCK_SIZE + 1);
  localparam int unsigned CFG_INDEX_W    = 2;

  localparam logic [HASH_W-1:0] GOLDEN_ADD = 64'h9e37_79b9_7f4a_7c15;
  localparam int unsigned MIX_SHL = 6;
  localparam int unsigned MIX_SHR = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_SIZE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_PREFIX = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NARROW_TOKENS  = 2'd2;

  // Staged item: token with the golden constant already added.
  typedef struct packed {
    logic [HASH_W-1:0] token_k;
    logic              start_chain;
  } cbph_item_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] hash;
  } cbph_result_t;

  // r ^ (vk + (r << 6) + (r >> 2)), vk = v + golden constant; zero maps to one
  function automatic logic [HASH_W-1:0] mix_pre(input logic [HASH_W-1:0] r,
                                                input logic [HASH_W-1:0] vk);
    logic [HASH_W-1:0] t;
    t = r ^ (vk + (r << MIX_SHL) + (r >> MIX_SHR));
    return (t == '0) ? HASH_W'(1) : t;
  endfunction

endpackage

[design/cbph_chain.sv]
// Chain state and per-item hash step of the chained block prefix hash.
// Depends on cbph_pkg.
module cbph_chain
  import cbph_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cbph_item_t          item,
  input  logic                advance,
  input  logic [HASH_W-1:0]   init_prefix,
  input  logic [COUNT_W-1:0]  eff_size,
  output cbph_result_t        result
);

  logic [HASH_W-1:0]  chain_hash;
  logic [HASH_W-1:0]  running_seed;
  logic [COUNT_W-1:0] tokens_in_block;

  logic [HASH_W-1:0]  chain_cur;
  logic [COUNT_W-1:0] count_cur;
  logic [COUNT_W-1:0] count_inc;
  logic [HASH_W-1:0]  seed_base;
  logic [HASH_W-1:0]  seed_mixed;
  logic [HASH_W-1:0]  seed_final;
  logic               done;

  always_comb begin
    chain_cur = item.start_chain ? init_prefix : chain_hash;
    count_cur = item.start_chain ? '0 : tokens_in_block;
    if (count_cur == '0) begin
      seed_base = (chain_cur != '0) ? mix_pre('0, chain_cur + GOLDEN_ADD) : '0;
    end else begin
      seed_base = running_seed;
    end
    seed_mixed = mix_pre(seed_base, item.token_k);
    seed_final = mix_pre(seed_mixed, GOLDEN_ADD);
    count_inc  = count_cur + COUNT_W'(1);
    done       = (count_inc >= eff_size);
  end

  assign result.done = done;
  assign result.hash = seed_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_hash      <= '0;
      running_seed    <= '0;
      tokens_in_block <= '0;
    end else if (advance) begin
      if (done) begin
        chain_hash      <= seed_final;
        running_seed    <= seed_final;
        tokens_in_block <= '0;
      end else begin
        chain_hash      <= chain_cur;
        running_seed    <= seed_mixed;
        tokens_in_block <= count_inc;
      end
    end
  end

endmodule

[design/chained_block_prefix_hash.sv]
// Top level of the chained block prefix hash: config registers, input stage,
// output register. Depends on cbph_pkg and cbph_chain.
//
// Usage:
//   Tokens enter on in_valid/in_stall with token and start_chain. Each time
//   a block reaches its configured token count, one block_hash leaves on
//   out_valid/out_stall; other tokens give no item. start_chain reloads the
//   chain from initial_prefix and opens a new block with that token.
//   Config is written through cfg_write/cfg_index/cfg_data while idle.
//   Throughput: one token per cycle while in_stall is low. A token's hash
//   passes through the input stage, then the output register.
//   The per-token step (up to three chained 64-bit mixes in the state
//   update) sets the clock period.
//   Reset: config returns to block length 128, no prefix, full-width tokens;
//   chain, partial block and both stages are cleared.
//   Stall: a held result stays on block_hash; tokens that finish no block
//   keep flowing, and in_stall rises only when a block-ending token waits
//   behind a stalled result.
module chained_block_prefix_hash
  import cbph_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [HASH_W-1:0]       cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [HASH_W-1:0]       token,
  input  logic                    start_chain,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [HASH_W-1:0]       block_hash
);

  logic [BLOCK_SIZE_W-1:0] blk_len;
  logic [HASH_W-1:0]       initial_prefix;
  logic                    narrow_tokens;

  logic [COUNT_W-1:0]      eff_size;
  logic                    stage_valid;
  cbph_item_t              stage_item;
  cbph_item_t              stage_next;
  cbph_result_t            result;
  logic                    advance;
  logic                    in_accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_len        <= BLOCK_SIZE_W'(128);
      initial_prefix <= '0;
      narrow_tokens  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BLOCK_SIZE:     blk_len        <= cfg_data[BLOCK_SIZE_W-1:0];
        CFG_INITIAL_PREFIX: initial_prefix <= cfg_data;
        CFG_NARROW_TOKENS:  narrow_tokens  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (blk_len == '0) begin
      eff_size = COUNT_W'(1);
    end else if (blk_len > MAX_BLOCK_SIZE) begin
      eff_size = COUNT_W'(MAX_BLOCK_SIZE);
    end else begin
      eff_size = COUNT_W'(blk_len);
    end
  end

  always_comb begin
    stage_next.start_chain = start_chain;
    stage_next.token_k     = (narrow_tokens ? {32'b0, token[31:0]} : token) + GOLDEN_ADD;
  end

  assign advance   = stage_valid && (!result.done || !out_valid || !out_stall);
  assign in_stall  = stage_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_item <= stage_next;
    end
  end

  cbph_chain u_chain (
    .clk         (clk),
    .rst         (rst),
    .item        (stage_item),
    .advance     (advance),
    .init_prefix (initial_prefix),
    .eff_size    (eff_size),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.done) begin
      block_hash <= result.hash;
    end
  end

endmodule

[design/cbph_checker.sv]
// Port-level checks for chained_block_prefix_hash, attached by bind.
// Depends on cbph_pkg.
module cbph_checker
  import cbph_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [HASH_W-1:0]       block_hash
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(block_hash))
    else $error("stalled block_hash changed or dropped");

  a_hash_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> block_hash != '0)
    else $error("block_hash is zero");

  // with the output register empty the input stage always drains
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("in_stall with empty output register");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind chained_block_prefix_hash cbph_checker u_cbph_checker (.*);

[tb/chained_block_prefix_hash_test.sv]
`timescale 1ns / 1ps
// Self-checking test of chained_block_prefix_hash: random and directed token
// streams, a block-hash predictor in the bench, varied idle and stall rates.
// Depends on cbph_pkg and the chained_block_prefix_hash RTL.
module chained_block_prefix_hash_test;
  import cbph_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [HASH_W-1:0] ALL_ONES = {HASH_W{1'b1}};

  typedef struct {
    logic [HASH_W-1:0] tok;
    logic              start;
  } token_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [HASH_W-1:0]      cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [HASH_W-1:0]      token = '0;
  logic                   start_chain = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [HASH_W-1:0]      block_hash;

  token_item_t       pending_tokens[$];
  logic [HASH_W-1:0] expected_hashes[$];
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                errors = 0;

  // predictor state and register shadows
  logic [BLOCK_SIZE_W-1:0] sh_blk_len = 13'd128;
  logic [HASH_W-1:0]       sh_prefix = '0;
  logic                    sh_narrow = 1'b0;
  logic [HASH_W-1:0]       chain_state = '0;
  logic [HASH_W-1:0]       block_seed = '0;
  int unsigned             block_count = 0;

  chained_block_prefix_hash u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .token      (token),
    .start_chain(start_chain),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .block_hash (block_hash)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [HASH_W-1:0] golden_mix(input logic [HASH_W-1:0] r,
                                                   input logic [HASH_W-1:0] v);
    logic [HASH_W-1:0] t;
    t = r ^ (v + GOLDEN_ADD + (r << MIX_SHL) + (r >> MIX_SHR));
    return (t == '0) ? 64'd1 : t;
  endfunction

  function automatic void absorb_token(input logic [HASH_W-1:0] tok, input logic start);
    logic [HASH_W-1:0] v;
    int unsigned       limit;
    if (start) begin
      chain_state = sh_prefix;
      block_count = 0;
    end
    v = sh_narrow ? {32'd0, tok[31:0]} : tok;
    if (block_count == 0) begin
      block_seed = (chain_state != '0) ? golden_mix('0, chain_state) : '0;
    end
    block_seed = golden_mix(block_seed, v);
    block_count++;
    if (sh_blk_len == 0) limit = 1;
    else if (sh_blk_len > MAX_BLOCK_SIZE) limit = MAX_BLOCK_SIZE;
    else limit = 32'(sh_blk_len);
    if (block_count >= limit) begin
      block_seed = golden_mix(block_seed, '0);
      chain_state = block_seed;
      block_count = 0;
      expected_hashes.push_back(chain_state);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    token_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_token(token, start_chain);
      if (!in_valid || !in_stall) begin
        if (pending_tokens.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          it = pending_tokens.pop_front();
          in_valid <= 1'b1;
          token <= it.tok;
          start_chain <= it.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [HASH_W-1:0] exp_hash;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_hashes.size() == 0) begin
          $display("%0t: unexpected block_hash: expected none, actual %h", $time, block_hash);
          errors++;
        end else begin
          exp_hash = expected_hashes.pop_front();
          if (block_hash !== exp_hash) begin
            $display("%0t: block_hash mismatch: expected %h, actual %h",
                     $time, exp_hash, block_hash);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [HASH_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_BLOCK_SIZE:     sh_blk_len = data[BLOCK_SIZE_W-1:0];
      CFG_INITIAL_PREFIX: sh_prefix = data;
      CFG_NARROW_TOKENS:  sh_narrow = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_token(input logic [HASH_W-1:0] tok, input logic start);
    token_item_t it;
    it.tok = tok;
    it.start = start;
    pending_tokens.push_back(it);
  endtask

  // waits for every queued item and hash, then lets in-flight tokens settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_tokens.size() != 0 || in_valid || expected_hashes.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [HASH_W-1:0] rand_token();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ALL_ONES;
      2: return -GOLDEN_ADD;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [HASH_W-1:0] rand_blk_len();
    case ($urandom_range(0, 19))
      0: return 64'd0;
      1: return 64'($urandom_range(9, 64));
      2: return 64'd1;
      default: return 64'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [HASH_W-1:0] rand_prefix();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return ALL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: no start after reset, zero mix result on the first token
    write_reg(CFG_BLOCK_SIZE, 64'd1);
    push_token(-GOLDEN_ADD, 1'b0);
    push_token('0, 1'b0);
    push_token(ALL_ONES, 1'b0);
    push_token(-GOLDEN_ADD, 1'b1);
    wait_drained();

    write_reg(CFG_BLOCK_SIZE, 64'd3);
    write_reg(CFG_INITIAL_PREFIX, ALL_ONES);
    write_reg(CFG_NARROW_TOKENS, 64'd1);
    push_token(ALL_ONES, 1'b1);
    push_token(64'h0000_0000_ffff_ffff, 1'b0);
    push_token(64'hffff_ffff_0000_0000, 1'b0);
    push_token(64'h1234_5678_9abc_def0, 1'b0);
    push_token(ALL_ONES, 1'b1);             // partial block dropped
    push_token('0, 1'b0);
    push_token(64'h8000_0000_8000_0000, 1'b0);
    wait_drained();

    write_reg(CFG_UNUSED, {$urandom, $urandom});
    write_reg(CFG_BLOCK_SIZE, 64'd0);       // acts as one
    write_reg(CFG_NARROW_TOKENS, 64'd0);
    write_reg(CFG_INITIAL_PREFIX, 64'h0123_4567_89ab_cdef);
    push_token(ALL_ONES, 1'b1);
    push_token(64'h8000_0000_0000_0001, 1'b0);
    wait_drained();

    // size lowered with a block half done
    write_reg(CFG_BLOCK_SIZE, 64'd5);
    push_token({$urandom, $urandom}, 1'b1);
    push_token({$urandom, $urandom}, 1'b0);
    push_token({$urandom, $urandom}, 1'b0);
    wait_drained();
    write_reg(CFG_BLOCK_SIZE, 64'd2);
    push_token({$urandom, $urandom}, 1'b0);
    push_token({$urandom, $urandom}, 1'b0);
    push_token({$urandom, $urandom}, 1'b0);
    wait_drained();

    // largest and oversize lengths; the partial block carries into the phases
    write_reg(CFG_BLOCK_SIZE, 64'(MAX_BLOCK_SIZE));
    write_reg(CFG_INITIAL_PREFIX, rand_prefix());
    push_token(rand_token(), 1'b1);
    repeat (19) push_token(rand_token(), 1'b0);
    wait_drained();
    write_reg(CFG_BLOCK_SIZE, 64'h1fff);
    repeat (20) push_token(rand_token(), 1'b0);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      write_reg(CFG_BLOCK_SIZE, rand_blk_len());
      write_reg(CFG_INITIAL_PREFIX, rand_prefix());
      write_reg(CFG_NARROW_TOKENS, 64'($urandom_range(0, 1)));
      for (int half = 0; half < 2; half++) begin
        repeat (55) push_token(rand_token(), ($urandom_range(0, 99) < 4));
        wait_drained();                     // sender holds until all hashes are in
      end
    end

    repeat (10) @(negedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
